// File: rtl/core/civil_date_day_number_converter_unit_assert.svh
// Assertion helpers for the civil date converter.
`ifndef CIVIL_DATE_DAY_NUMBER_CONVERTER_UNIT_ASSERT_SVH
`define CIVIL_DATE_DAY_NUMBER_CONVERTER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CDDN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CDDN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cddn_pkg.sv
package cddn_pkg;

    localparam int NSTG = 10;

    typedef logic [NSTG-1:0] t_stage_mask;

    localparam longint EPOCH_SHIFT = 719468;
    localparam longint ERA_DAYS    = 146097;
    localparam longint ERA_LAST    = 146096;
    localparam longint ERA_YEARS   = 400;

    // Bias that makes the shifted day count non-negative before the era divide.
    localparam longint DAY_ERA_BIAS = 14700;
    localparam longint Z_OFFSET     = EPOCH_SHIFT + DAY_ERA_BIAS * ERA_DAYS;

    // Same idea for the year path.
    localparam longint YEAR_ERA_BIAS = 20972;
    localparam longint Y_OFFSET      = YEAR_ERA_BIAS * ERA_YEARS;

    // Era estimate: (zp >> 10) * M >> 32, low by at most two.
    localparam longint M_ERA0 = (longint'(1) << 42) / ERA_DAYS;
    // Exact reciprocals: ceil(2^k / d).
    localparam longint M_Y400 = ((longint'(1) << 34) + ERA_YEARS - 1) / ERA_YEARS;
    localparam longint M_1460 = ((longint'(1) << 29) + 1460 - 1) / 1460;
    localparam longint M_365  = ((longint'(1) << 27) + 365 - 1) / 365;
    localparam longint M_153  = ((longint'(1) << 19) + 153 - 1) / 153;

    localparam longint REM_LIMIT = 3 * ERA_DAYS;

    // (153 * mm + 2) / 5, days from March 1st to the start of shifted month mm
    function automatic logic [8:0] days_before(input logic [3:0] mm);
        logic [8:0] v;
        unique case (mm)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // yoe / 100 for yoe below 400
    function automatic logic [1:0] cent_of(input logic [8:0] yoe);
        logic [1:0] c;
        priority if (yoe >= 9'd300) c = 2'd3;
        else if (yoe >= 9'd200)     c = 2'd2;
        else if (yoe >= 9'd100)     c = 2'd1;
        else                        c = 2'd0;
        return c;
    endfunction

endpackage

// File: rtl/core/civil_date_day_number_converter_unit.sv
// Channel   | handshake                      | payload
// ----------+--------------------------------+----------------------------------------
// request   | i_in_valid  / o_in_stall       | i_func, i_day_count_in, i_year_in,
//           |                                | i_month_in, i_mday_in
// result    | o_out_valid / i_out_stall      | o_day_count_out, o_year_out,
//           |                                | o_month_out, o_mday_out
//
// Ten register stages, one request accepted per cycle unless o_in_stall is high.
// The depth is set by the day-count path: era divide, estimate correction,
// year-of-era divide and month divide each get their own stages.
// Synchronous active-low reset clears only the stage valid bits.
// Each stage holds only while it is full and the stage after it is blocked,
// so empty stages close up behind a stalled result.
`include "civil_date_day_number_converter_unit_assert.svh"

module civil_date_day_number_converter_unit
    import cddn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic signed [31:0] i_day_count_in,
    input  logic signed [23:0] i_year_in,
    input  logic        [3:0]  i_month_in,
    input  logic        [4:0]  i_mday_in,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_day_count_out,
    output logic signed [23:0] o_year_out,
    output logic        [3:0]  o_month_out,
    output logic        [4:0]  o_mday_out
);

    t_stage_mask r_vld;
    t_stage_mask w_rdy;
    logic [NSTG-1:0] r_func;

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_stall = !w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_func[0] <= i_func;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_func[k] <= r_func[k-1];
            end
        end
    end

    // ---------------- stage 0: bias inputs ----------------
    logic        [32:0] r0_zp;
    logic        [24:0] r0_yy;
    logic signed [10:0] r0_doy1;

    logic               w0_early;
    logic        [3:0]  w0_mm;
    logic        [24:0] w0_ym;

    always_comb begin
        w0_early = (i_month_in <= 4'd2);
        w0_mm    = w0_early ? (i_month_in + 4'd9) : (i_month_in - 4'd3);
        w0_ym    = 25'(i_year_in) - 25'(w0_early);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_zp   <= 33'(34'(i_day_count_in) + 34'(Z_OFFSET));
            r0_yy   <= w0_ym + 25'(Y_OFFSET);
            r0_doy1 <= signed'({2'b00, days_before(w0_mm)}) + signed'(11'(i_mday_in))
                       - 11'sd1;
        end
    end

    // ---------------- stage 1: reciprocal multiplies ----------------
    logic        [14:0] r1_qe;
    logic        [32:0] r1_zp;
    logic        [15:0] r1_q1;
    logic        [24:0] r1_yy;
    logic signed [10:0] r1_doy1;

    logic [47:0] w1_p0;
    logic [50:0] w1_p1;

    always_comb begin
        w1_p0 = 48'(r0_zp[32:10]) * 48'(M_ERA0);
        w1_p1 = 51'(r0_yy) * 51'(M_Y400);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_qe   <= w1_p0[46:32];
            r1_zp   <= r0_zp;
            r1_q1   <= w1_p1[49:34];
            r1_yy   <= r0_yy;
            r1_doy1 <= r0_doy1;
        end
    end

    // ---------------- stage 2: remainders ----------------
    logic        [18:0] r2_rem;
    logic        [14:0] r2_qe;
    logic        [8:0]  r2_yoe1;
    logic signed [15:0] r2_era1;
    logic signed [10:0] r2_doy1;

    logic [32:0] w2_qd;
    logic [24:0] w2_yd;

    always_comb begin
        w2_qd = 33'(r1_qe) * 33'(ERA_DAYS);
        w2_yd = 25'(r1_q1) * 25'(ERA_YEARS);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_rem  <= 19'(r1_zp - w2_qd);
            r2_qe   <= r1_qe;
            r2_yoe1 <= 9'(r1_yy - w2_yd);
            r2_era1 <= signed'(r1_q1 - 16'(YEAR_ERA_BIAS));
            r2_doy1 <= r1_doy1;
        end
    end

    // ---------------- stage 3: era correction, day of era ----------------
    logic        [17:0] r3_doe0;
    logic signed [15:0] r3_era0;
    logic        [31:0] r3_eday;
    logic signed [19:0] r3_doe1;

    logic        [17:0] w3_doe0;
    logic        [14:0] w3_q;
    logic        [17:0] w3_y365;
    logic signed [33:0] w3_eday;

    always_comb begin
        priority if (r2_rem >= 19'(2 * ERA_DAYS)) begin
            w3_doe0 = 18'(r2_rem - 19'(2 * ERA_DAYS));
            w3_q    = r2_qe + 15'd2;
        end else if (r2_rem >= 19'(ERA_DAYS)) begin
            w3_doe0 = 18'(r2_rem - 19'(ERA_DAYS));
            w3_q    = r2_qe + 15'd1;
        end else begin
            w3_doe0 = 18'(r2_rem);
            w3_q    = r2_qe;
        end
        w3_y365 = 18'(r2_yoe1) * 18'd365;
        w3_eday = 34'(r2_era1) * 34'(ERA_DAYS);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r3_doe0 <= w3_doe0;
            r3_era0 <= signed'(16'(w3_q) - 16'(DAY_ERA_BIAS));
            r3_eday <= w3_eday[31:0];
            r3_doe1 <= signed'({2'b00, w3_y365}) + signed'(20'(r2_yoe1[8:2]))
                       - signed'(20'(cent_of(r2_yoe1))) + 20'(r2_doy1);
        end
    end

    // ---------------- stage 4: leap corrections, final day count ----------------
    logic [17:0] r4_doe0;
    logic [6:0]  r4_d1460;
    logic [2:0]  r4_d36524;
    logic        r4_dlast;
    logic [23:0] r4_eyr;
    logic [31:0] r4_days;

    logic        [36:0] w4_p;
    logic signed [23:0] w4_eyr;

    always_comb begin
        w4_p   = 37'(r3_doe0) * 37'(M_1460);
        w4_eyr = 24'(r3_era0) * 24'(ERA_YEARS);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r4_doe0   <= r3_doe0;
            r4_d1460  <= w4_p[35:29];
            r4_d36524 <= 3'(r3_doe0 >= 18'd36524) + 3'(r3_doe0 >= 18'd73048)
                         + 3'(r3_doe0 >= 18'd109572) + 3'(r3_doe0 >= 18'(ERA_LAST));
            r4_dlast  <= (r3_doe0 == 18'(ERA_LAST));
            r4_eyr    <= w4_eyr;
            r4_days   <= r3_eday + 32'(r3_doe1) - 32'(EPOCH_SHIFT);
        end
    end

    // ---------------- stage 5: numerator of year of era ----------------
    logic [17:0] r5_t;
    logic [17:0] r5_doe0;
    logic [23:0] r5_eyr;
    logic [31:0] r5_days;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r5_t    <= r4_doe0 - 18'(r4_d1460) + 18'(r4_d36524) - 18'(r4_dlast);
            r5_doe0 <= r4_doe0;
            r5_eyr  <= r4_eyr;
            r5_days <= r4_days;
        end
    end

    // ---------------- stage 6: year of era ----------------
    logic [8:0]  r6_yoe;
    logic [17:0] r6_doe0;
    logic [23:0] r6_eyr;
    logic [31:0] r6_days;

    logic [36:0] w6_p;

    assign w6_p = 37'(r5_t) * 37'(M_365);

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r6_yoe  <= w6_p[35:27];
            r6_doe0 <= r5_doe0;
            r6_eyr  <= r5_eyr;
            r6_days <= r5_days;
        end
    end

    // ---------------- stage 7: day of year ----------------
    logic [8:0]  r7_doy;
    logic [8:0]  r7_yoe;
    logic [23:0] r7_eyr;
    logic [31:0] r7_days;

    logic [17:0] w7_ystart;

    assign w7_ystart = 18'(r6_yoe) * 18'd365 + 18'(r6_yoe[8:2]) - 18'(cent_of(r6_yoe));

    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            r7_doy  <= 9'(r6_doe0 - w7_ystart);
            r7_yoe  <= r6_yoe;
            r7_eyr  <= r6_eyr;
            r7_days <= r6_days;
        end
    end

    // ---------------- stage 8: shifted month ----------------
    logic [3:0]  r8_mp;
    logic [8:0]  r8_doy;
    logic [8:0]  r8_yoe;
    logic [23:0] r8_eyr;
    logic [31:0] r8_days;

    logic [10:0] w8_num;
    logic [22:0] w8_p;

    always_comb begin
        w8_num = 11'(r7_doy) * 11'd5 + 11'd2;
        w8_p   = 23'(w8_num) * 23'(M_153);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[8]) begin
            r8_mp   <= w8_p[22:19];
            r8_doy  <= r7_doy;
            r8_yoe  <= r7_yoe;
            r8_eyr  <= r7_eyr;
            r8_days <= r7_days;
        end
    end

    // ---------------- stage 9: result register ----------------
    logic [31:0] r9_day_count;
    logic [23:0] r9_year;
    logic [3:0]  r9_month;
    logic [4:0]  r9_mday;

    logic [3:0]  w9_mon;
    logic [8:0]  w9_mday;
    logic [23:0] w9_year;

    always_comb begin
        w9_mon  = (r8_mp < 4'd10) ? (r8_mp + 4'd3) : (r8_mp - 4'd9);
        w9_mday = r8_doy - days_before(r8_mp) + 9'd1;
        w9_year = r8_eyr + 24'(r8_yoe) + 24'(w9_mon <= 4'd2);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[9]) begin
            if (r_func[8]) begin
                r9_day_count <= r8_days;
                r9_year      <= '0;
                r9_month     <= '0;
                r9_mday      <= '0;
            end else begin
                r9_day_count <= '0;
                r9_year      <= w9_year;
                r9_month     <= w9_mon;
                r9_mday      <= w9_mday[4:0];
            end
        end
    end

    assign o_out_valid     = r_vld[NSTG-1];
    assign o_day_count_out = signed'(r9_day_count);
    assign o_year_out      = signed'(r9_year);
    assign o_month_out     = r9_month;
    assign o_mday_out      = r9_mday;

    // ---------------- checks ----------------
    `CDDN_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall,
        (&r_vld) && i_out_stall, "input stalled while pipeline has room")
    `CDDN_ASSERT_NOW(a_era_estimate_close, i_clk, i_rst_n, r_vld[2],
        r2_rem < 19'(REM_LIMIT), "era quotient estimate off by more than two")
    `CDDN_ASSERT_NOW(a_month_shift_range, i_clk, i_rst_n, r_vld[8] && !r_func[8],
        r8_mp <= 4'd11, "shifted month out of range")
    `CDDN_ASSERT_NEXT(a_blocked_stage_holds, i_clk, i_rst_n, r_vld[3] && !w_rdy[3],
        r_vld[3] && $stable(r3_doe0), "blocked stage lost its request")

endmodule
